// ===== rtl/sbwh_pkg.sv =====
`default_nettype none
package sbwh_pkg;

	// Counter store geometry.
	localparam int MAX_BINS    = 64;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_AW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	// Field widths of the ports.
	localparam int IDX_W   = 6;
	localparam int SCORE_W = 21;
	localparam int BW_W    = 16;
	localparam int PB_W    = 5;
	localparam int OUT_W   = 32;

	// Width that holds both a bin index and the largest store address.
	localparam int CMP_W = ((BIN_AW > IDX_W) ? BIN_AW : IDX_W) + 1;

	// Restoring divider: one quotient bit per cycle over the dividend.
	localparam int DIV_STEPS = SCORE_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Configuration register indexes (word address on the APB port).
	localparam logic REG_BIN_WIDTH     = 1'b0;
	localparam logic REG_POSITIVE_BINS = 1'b1;

	localparam logic [BW_W-1:0] BIN_WIDTH_RESET     = BW_W'(100);
	localparam logic [PB_W-1:0] POSITIVE_BINS_RESET = PB_W'(10);

	// Operation codes.
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Request to the counter store.
	typedef struct packed {
		logic              record;
		logic              won;
		logic [BIN_AW-1:0] addr;
	} sbwh_req_t;

endpackage
`default_nettype wire

// ===== rtl/sbwh_divider.sv =====
`default_nettype none
module sbwh_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sbwh_pkg::SCORE_W-1:0] dividend,
	input  wire logic [sbwh_pkg::BW_W-1:0]    divisor,
	output logic                              done,
	output logic [sbwh_pkg::SCORE_W-1:0]      quotient
);
	import sbwh_pkg::*;

	logic [SCORE_W-1:0] shift_q;
	logic [BW_W-1:0]    rem_q;
	logic [BW_W-1:0]    divisor_q;
	logic [DIV_CW-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;

	logic [BW_W:0] trial;
	logic          fits;
	logic [BW_W:0] diff;
	logic [BW_W-1:0] rem_nxt;

	// One dividend bit enters the partial remainder each cycle, and the
	// quotient bit shifts into the vacated low end of the same register.
	assign trial   = {rem_q, shift_q[SCORE_W-1]};
	assign fits    = trial >= {1'b0, divisor_q};
	assign diff    = trial - {1'b0, divisor_q};
	assign rem_nxt = fits ? diff[BW_W-1:0] : trial[BW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + DIV_CW'(1);
			if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (run_q) begin
			shift_q <= {shift_q[SCORE_W-2:0], fits};
			rem_q   <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

endmodule
`default_nettype wire

// ===== rtl/sbwh_counter_store.sv =====
`default_nettype none
module sbwh_counter_store (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	input  wire sbwh_pkg::sbwh_req_t               req,
	output logic                                   rsp_valid,
	output logic [sbwh_pkg::COUNT_WIDTH-1:0]       win_count,
	output logic [sbwh_pkg::COUNT_WIDTH-1:0]       sample_count
);
	import sbwh_pkg::*;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + COUNT_WIDTH'(1);
	endfunction

	logic [COUNT_WIDTH-1:0] win_mem    [MAX_BINS];
	logic [COUNT_WIDTH-1:0] sample_mem [MAX_BINS];
	logic [MAX_BINS-1:0]    written_q;

	logic                   vld_s1;
	sbwh_req_t              req_s1;
	logic                   hit_s1;
	logic [COUNT_WIDTH-1:0] win_rd_s1;
	logic [COUNT_WIDTH-1:0] smp_rd_s1;

	logic                   vld_s2;
	logic [COUNT_WIDTH-1:0] win_s2;
	logic [COUNT_WIDTH-1:0] smp_s2;

	logic [COUNT_WIDTH-1:0] win_cur;
	logic [COUNT_WIDTH-1:0] smp_cur;
	logic [COUNT_WIDTH-1:0] win_nxt;
	logic [COUNT_WIDTH-1:0] smp_nxt;
	logic                   wr_en;

	// An entry never written since reset reads as zero.
	assign win_cur = hit_s1 ? win_rd_s1 : '0;
	assign smp_cur = hit_s1 ? smp_rd_s1 : '0;
	assign win_nxt = (req_s1.record && req_s1.won) ? sat_inc(win_cur) : win_cur;
	assign smp_nxt = req_s1.record ? sat_inc(smp_cur) : smp_cur;
	assign wr_en   = vld_s1 && req_s1.record;

	always_ff @(posedge clk) begin
		win_rd_s1 <= win_mem[req.addr];
		smp_rd_s1 <= sample_mem[req.addr];
		if (wr_en) begin
			win_mem[req_s1.addr]    <= win_nxt;
			sample_mem[req_s1.addr] <= smp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			written_q <= '0;
			req_s1    <= '0;
			hit_s1    <= 1'b0;
			win_s2    <= '0;
			smp_s2    <= '0;
		end else begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			if (req_valid) begin
				req_s1 <= req;
				hit_s1 <= written_q[req.addr];
			end
			if (wr_en) begin
				written_q[req_s1.addr] <= 1'b1;
			end
			if (vld_s1) begin
				win_s2 <= win_nxt;
				smp_s2 <= smp_nxt;
			end
		end
	end

	assign rsp_valid    = vld_s2;
	assign win_count    = win_s2;
	assign sample_count = smp_s2;

endmodule
`default_nettype wire

// ===== rtl/score_bucket_win_histogram_unit.sv =====
`default_nettype none
// Win-rate histogram of signed evaluation scores.
//
// Command channel: a request is taken at a rising edge where start is high
// and busy is low. operation selects between recording a sample (score,
// mover_won) and reading one bin's counters (read_bin). Exactly one result
// follows each request: done is high for a single cycle while bin_index,
// win_total and sample_total hold that result. The receiver cannot stall,
// so the result is gone after that cycle.
//
// Sequence: a record request runs a bit-serial restoring divide of the
// score magnitude by bin_width, one quotient bit per cycle, then a
// two-stage read-modify-write of the counter memories. A read request
// skips the divider and goes straight to the counter store. busy drops
// in the cycle after done.
//
// Configuration is an APB port: bin_width at byte address 0, positive_bins
// at byte address 4, pready tied high. Write registers only while idle.
// Reset restores bin_width 100 and positive_bins 10 and clears all counters
// at once through per-entry written flags; no clearing pass is needed.
module score_bucket_win_histogram_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Command channel.
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         operation,
	input  wire logic [sbwh_pkg::SCORE_W-1:0] score,
	input  wire logic                         mover_won,
	input  wire logic [sbwh_pkg::IDX_W-1:0]   read_bin,
	// Result channel.
	output logic                              done,
	output logic [sbwh_pkg::IDX_W-1:0]        bin_index,
	output logic [sbwh_pkg::OUT_W-1:0]        win_total,
	output logic [sbwh_pkg::OUT_W-1:0]        sample_total,
	// Configuration port.
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import sbwh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LOOKUP
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [BW_W-1:0] bin_width_q;
	logic [PB_W-1:0] positive_bins_q;
	logic            cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q     <= BIN_WIDTH_RESET;
			positive_bins_q <= POSITIVE_BINS_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_BIN_WIDTH:     bin_width_q     <= pwdata[BW_W-1:0];
				REG_POSITIVE_BINS: positive_bins_q <= pwdata[PB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BIN_WIDTH:     prdata = {{(32-BW_W){1'b0}}, bin_width_q};
			REG_POSITIVE_BINS: prdata = {{(32-PB_W){1'b0}}, positive_bins_q};
			default:           prdata = '0;
		endcase
	end

	// Request acceptance and divider setup. A zero bin width acts as one.
	// Rounding to the nearest bin is a truncating divide of
	// |score| + (width-1)/2; samples inside the zero bin give a zero quotient.
	logic               accept;
	logic [BW_W-1:0]    grid;
	logic [SCORE_W-1:0] magnitude;
	logic [SCORE_W-1:0] dividend;
	logic               div_start;
	logic               div_done;
	logic [SCORE_W-1:0] quotient;

	assign accept    = start && !busy;
	assign grid      = (bin_width_q == '0) ? BW_W'(1) : bin_width_q;
	assign magnitude = score[SCORE_W-1] ? (~score + SCORE_W'(1)) : score;
	assign dividend  = magnitude + SCORE_W'((grid - BW_W'(1)) >> 1);
	assign div_start = accept && (operation == OP_RECORD);

	sbwh_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (grid),
		.done     (div_done),
		.quotient (quotient)
	);

	// Bin from the quotient: centered on positive_bins, clamped to the
	// range 0..2*positive_bins and to the last entry of the store.
	logic             negative_q;
	logic             won_q;
	logic             beyond;
	logic [IDX_W-1:0] zero_bin;
	logic [IDX_W-1:0] top_bin;
	logic [IDX_W-1:0] q_low;
	logic [IDX_W-1:0] raw_bin;
	logic [IDX_W-1:0] rec_bin;

	assign zero_bin = IDX_W'(positive_bins_q);
	assign top_bin  = IDX_W'({positive_bins_q, 1'b0});
	assign q_low    = IDX_W'(quotient[PB_W-1:0]);
	assign beyond   = (quotient[SCORE_W-1:PB_W] != '0) ||
	                  (quotient[PB_W-1:0] > positive_bins_q);

	always_comb begin
		if (negative_q) begin
			raw_bin = beyond ? '0 : zero_bin - q_low;
		end else begin
			raw_bin = beyond ? top_bin : zero_bin + q_low;
		end
		if (CMP_W'(raw_bin) > CMP_W'(MAX_BINS - 1)) begin
			rec_bin = IDX_W'(MAX_BINS - 1);
		end else begin
			rec_bin = raw_bin;
		end
	end

	// Sequencer and store request.
	logic             req_go_q;
	sbwh_req_t        req_q;
	logic [IDX_W-1:0] bin_q;
	logic             out_of_range_q;
	logic             rsp_valid;
	logic [COUNT_WIDTH-1:0] win_count;
	logic [COUNT_WIDTH-1:0] sample_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			req_go_q       <= 1'b0;
			req_q          <= '0;
			bin_q          <= '0;
			out_of_range_q <= 1'b0;
			negative_q     <= 1'b0;
			won_q          <= 1'b0;
		end else begin
			req_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_READ) begin
							req_go_q       <= 1'b1;
							req_q.record   <= 1'b0;
							req_q.won      <= 1'b0;
							req_q.addr     <= BIN_AW'(read_bin);
							bin_q          <= read_bin;
							out_of_range_q <= CMP_W'(read_bin) > CMP_W'(MAX_BINS - 1);
							state_q        <= ST_LOOKUP;
						end else begin
							negative_q     <= score[SCORE_W-1];
							won_q          <= mover_won;
							out_of_range_q <= 1'b0;
							state_q        <= ST_DIVIDE;
						end
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						req_go_q     <= 1'b1;
						req_q.record <= 1'b1;
						req_q.won    <= won_q;
						req_q.addr   <= BIN_AW'(rec_bin);
						bin_q        <= rec_bin;
						state_q      <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (rsp_valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	sbwh_counter_store u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_go_q),
		.req          (req_q),
		.rsp_valid    (rsp_valid),
		.win_count    (win_count),
		.sample_count (sample_count)
	);

	// A read beyond the store returns zero counts and echoes the bin.
	assign done         = rsp_valid;
	assign bin_index    = bin_q;
	assign win_total    = out_of_range_q ? '0 : OUT_W'(win_count);
	assign sample_total = out_of_range_q ? '0 : OUT_W'(sample_count);

	// A result only ever ends a request that was in flight.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a request in flight");

	// The sequencer frees the command channel as the strobe ends, and the strobe does not repeat.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy && !done)
		else $error("block still busy or strobing after its result");

	// A record request always occupies the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_RECORD) |=> (state_q == ST_DIVIDE))
		else $error("record request did not start the divider");

	// Wins only ever count alongside a sample, so they never exceed samples.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((COUNT_WIDTH > OUT_W) || (win_total <= sample_total)))
		else $error("win count exceeds sample count");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
// Self-checking bench for the score histogram unit.
//
// Requests go in over the command channel (start/busy). Each request
// returns exactly one result, marked by done for one cycle. The receiver
// cannot hold results off, so the bench never stalls them.
//
// The bench keeps its own copy of the two configuration registers and of
// both counter stores. Each request updates that copy at the edge where
// it is accepted, and the expected result is queued there. A checker
// process compares every done cycle against the oldest queued result,
// field by field. Because the block finishes one request before it takes
// the next, results come back in request order.
//
// Configuration is written over APB only once the block has drained.
// Every write is read back. The run goes through the reset settings, the
// extremes of both registers (including a bin width of zero, which the
// block treats as one), and a mix of random settings.
//
// Signals are driven with nonblocking assignments at the rising edge. All
// sampling happens right after the edge, before any flop updates land, so
// nothing depends on the order of events within a time step.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbwh_pkg::*;

	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_REQUESTS = 122;
	// The drain wait outlasts a whole record request, so it covers any stray result.
	localparam int DRAIN_CYCLES   = 32;
	// Slowest run: about 1100 requests, each a full record followed by the
	// longest idle burst. The limit lies above that total.
	localparam int CYCLE_LIMIT    = 500000;

	typedef struct {
		logic [IDX_W-1:0] bin;
		logic [OUT_W-1:0] wins;
		logic [OUT_W-1:0] samples;
	} bin_counts_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                operation    = OP_RECORD;
	logic [SCORE_W-1:0]  score        = '0;
	logic                mover_won    = 1'b0;
	logic [IDX_W-1:0]    read_bin     = '0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [2:0]          paddr        = '0;
	logic [31:0]         pwdata       = '0;
	logic                busy;
	logic                done;
	logic [IDX_W-1:0]    bin_index;
	logic [OUT_W-1:0]    win_total;
	logic [OUT_W-1:0]    sample_total;
	logic [31:0]         prdata;
	logic                pready;

	// Predicted state of the block.
	logic [BW_W-1:0]        model_bin_width     = BIN_WIDTH_RESET;
	logic [PB_W-1:0]        model_positive_bins = POSITIVE_BINS_RESET;
	logic [COUNT_WIDTH-1:0] win_count    [MAX_BINS];
	logic [COUNT_WIDTH-1:0] sample_count [MAX_BINS];

	bin_counts_t expected_counts[$];
	int          mismatches  = 0;
	int          cycle_count = 0;

	score_bucket_win_histogram_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.score        (score),
		.mover_won    (mover_won),
		.read_bin     (read_bin),
		.done         (done),
		.bin_index    (bin_index),
		.win_total    (win_total),
		.sample_total (sample_total),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5ns clk = ~clk;

	// The run must finish well inside the limit. Hitting it means a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle_count);
			$display("** score_bucket_win_histogram_unit: FAILED **");
			$finish;
		end
	end

	// Rounds a score to its bin. The zero bin is the closed range of plus or
	// minus half a bin width. Outside it, magnitudes are rounded with
	// truncating division, so even widths round slightly differently on
	// the two sides of a bin edge. The index is clamped to the used bins
	// and to the store.
	function automatic int score_to_bin(logic [SCORE_W-1:0] raw);
		longint s, g, half, zero, top, idx;
		s    = longint'(signed'(raw));
		g    = (model_bin_width == '0) ? 1 : longint'(model_bin_width);
		half = g / 2;
		zero = longint'(model_positive_bins);
		top  = zero * 2;
		if (s >= -half && s <= half)
			idx = zero;
		else if (s > 0)
			idx = zero + (s + (g - 1) / 2) / g;
		else
			idx = zero - ((-s + (g - 1) / 2) / g);
		if (idx < 0)
			idx = 0;
		if (idx > top)
			idx = top;
		if (idx > MAX_BINS - 1)
			idx = MAX_BINS - 1;
		return int'(idx);
	endfunction

	// Counters stick at all ones instead of wrapping.
	function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	// Applies one accepted request to the predicted counters and queues the
	// result it must produce.
	function automatic void predict_histogram(logic op, logic [SCORE_W-1:0] sc,
			logic won, logic [IDX_W-1:0] rb);
		bin_counts_t r;
		int          b;
		if (op == OP_READ) begin
			// A 6-bit bin number always lands inside a 64-entry store; the
			// zero answer for an address past the store is kept for other sizes.
			r.bin = rb;
			if (int'(rb) < MAX_BINS) begin
				r.wins    = OUT_W'(win_count[rb]);
				r.samples = OUT_W'(sample_count[rb]);
			end else begin
				r.wins    = '0;
				r.samples = '0;
			end
		end else begin
			b = score_to_bin(sc);
			if (won)
				win_count[b] = bump(win_count[b]);
			sample_count[b] = bump(sample_count[b]);
			r.bin     = IDX_W'(b);
			r.wins    = OUT_W'(win_count[b]);
			r.samples = OUT_W'(sample_count[b]);
		end
		expected_counts.insert(expected_counts.size(), r);
	endfunction

	// Result checker: every done cycle must match the oldest queued result.
	always @(posedge clk) begin
		bin_counts_t want;
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: result with none expected: bin %0d wins %0d samples %0d",
					$realtime, bin_index, win_total, sample_total);
				mismatches++;
			end else begin
				want = expected_counts.pop_front();
				if (bin_index !== want.bin) begin
					$display("%0t: bin_index expected %0d actual %0d",
						$realtime, want.bin, bin_index);
					mismatches++;
				end
				if (win_total !== want.wins) begin
					$display("%0t: win_total (bin %0d) expected %0d actual %0d",
						$realtime, want.bin, want.wins, win_total);
					mismatches++;
				end
				if (sample_total !== want.samples) begin
					$display("%0t: sample_total (bin %0d) expected %0d actual %0d",
						$realtime, want.bin, want.samples, sample_total);
					mismatches++;
				end
			end
		end
	end

	// Presents one request and returns at the edge where it is accepted.
	// start stays high on return, so the next request can follow right away.
	task automatic send_request(input logic op, input logic [SCORE_W-1:0] sc,
			input logic won, input logic [IDX_W-1:0] rb);
		start     <= 1'b1;
		operation <= op;
		score     <= sc;
		mover_won <= won;
		read_bin  <= rb;
		do @(posedge clk); while (busy);
		predict_histogram(op, sc, won, rb);
	endtask

	task automatic record_sample(input int sc, input logic won);
		send_request(OP_RECORD, SCORE_W'(sc), won, IDX_W'($urandom));
	endtask

	task automatic read_counts(input int rb);
		send_request(OP_READ, SCORE_W'($urandom), 1'($urandom), IDX_W'(rb));
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 16)) @(posedge clk);
	endtask

	// Waits until every queued result has come back, then a little longer,
	// so that the block is idle.
	task automatic drain_requests();
		start <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: a setup phase, then access until pready, then the bus goes
	// idle.
	task automatic write_register(input logic which, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (which == REG_BIN_WIDTH)
			model_bin_width = value[BW_W-1:0];
		else
			model_positive_bins = value[PB_W-1:0];
		@(posedge clk);
	endtask

	// APB read, compared with the predicted register value.
	task automatic check_register(input logic which);
		logic [31:0] want;
		want = (which == REG_BIN_WIDTH) ? 32'(model_bin_width) : 32'(model_positive_bins);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {which, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d read expected %0d actual %0d",
				$realtime, which, want, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_histogram_config(input int bw, input int pb);
		drain_requests();
		write_register(REG_BIN_WIDTH, 32'(bw));
		write_register(REG_POSITIVE_BINS, 32'(pb));
		check_register(REG_BIN_WIDTH);
		check_register(REG_POSITIVE_BINS);
	endtask

	// Random score that is usually near a bin center or a bin edge. The rest
	// are raw 21-bit values, which cover every bit and drive the clamps.
	function automatic logic [SCORE_W-1:0] pick_score();
		longint g, k, s;
		g = (model_bin_width == '0) ? 1 : longint'(model_bin_width);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				k = longint'($urandom_range(0, 2 * int'(model_positive_bins) + 4))
					- longint'(model_positive_bins) - 2;
				s = k * g + longint'($urandom_range(0, int'(g))) - g / 2;
			end
			6, 7: begin
				s = g / 2 + longint'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1))
					s = -s;
			end
			default: return SCORE_W'($urandom);
		endcase
		if (s > 1048575)
			s = 1048575;
		if (s < -1048576)
			s = -1048576;
		return SCORE_W'(s);
	endfunction

	// Reset values of both registers, and samples at the default width of
	// 100 on both sides of the zero-bin edges and at the score extremes.
	task automatic test_reset_defaults();
		check_register(REG_BIN_WIDTH);
		check_register(REG_POSITIVE_BINS);
		record_sample(0, 1'b1);
		record_sample(50, 1'b0);
		record_sample(-50, 1'b1);
		record_sample(51, 1'b1);
		record_sample(-51, 1'b0);
		record_sample(150, 1'b1);
		record_sample(151, 1'b1);
		record_sample(1048575, 1'b1);
		record_sample(-1048576, 1'b0);
		read_counts(11);
		read_counts(20);
		// Bins above the used range have never been touched.
		read_counts(63);
	endtask

	// Width zero (behaves as one) with the most bins, an even width where
	// rounding is lopsided, and the widest bins with a single bin.
	task automatic test_width_extremes();
		set_histogram_config(0, 31);
		record_sample(0, 1'b1);
		record_sample(1, 1'b0);
		record_sample(-1, 1'b1);
		record_sample(1048575, 1'b1);
		set_histogram_config(4, 3);
		record_sample(2, 1'b1);
		record_sample(3, 1'b0);
		record_sample(6, 1'b1);
		record_sample(7, 1'b1);
		record_sample(-7, 1'b0);
		set_histogram_config(65535, 0);
		record_sample(-1048576, 1'b1);
		record_sample(32767, 1'b1);
		read_counts(0);
		// A bin used under the earlier setting keeps its counts.
		read_counts(62);
	endtask

	// Phases of random traffic, each under its own setting. The last phase
	// runs with no idle gaps.
	task automatic test_random_traffic();
		int  bw_list [RANDOM_PHASES] = '{100, 1, 0, 65535, 65535, 3, 4, -1, -1};
		int  pb_list [RANDOM_PHASES] = '{10, 31, 31, 0, 31, 5, 0, -1, -1};
		int  bw, pb;
		bit  quiet;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			bw = bw_list[phase];
			pb = pb_list[phase];
			if (bw < 0)
				bw = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(0, 65535);
			if (pb < 0)
				pb = $urandom_range(0, 31);
			set_histogram_config(bw, pb);
			quiet = 1'b0;
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// Stretches with and without idle gaps.
				if (n % 20 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1))
						read_counts($urandom_range(0, 2 * int'(model_positive_bins) + 1));
					else
						read_counts($urandom_range(0, 63));
				end else begin
					send_request(OP_RECORD, pick_score(), 1'($urandom), IDX_W'($urandom));
				end
				if (phase != RANDOM_PHASES - 1 && !quiet && $urandom_range(0, 3) == 0)
					idle_burst();
			end
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_BINS; i++) begin
			win_count[i]    = '0;
			sample_count[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_width_extremes();
		test_random_traffic();

		drain_requests();
		if (mismatches == 0)
			$display("** score_bucket_win_histogram_unit: PASSED **");
		else
			$display("** score_bucket_win_histogram_unit: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/sbwh_pkg.sv
rtl/sbwh_divider.sv
rtl/sbwh_counter_store.sv
rtl/score_bucket_win_histogram_unit.sv
sim/tb.sv
